// ===== rtl/core/ttip_pkg.sv =====
// Shared types, constants and helpers of the trajectory table interpolator.
package ttip_pkg;

  localparam int NUM_POINTS_DEF = 32;
  localparam int NUM_VALUES     = 8;
  localparam int VAL_W          = 32;
  localparam int ROW_W          = NUM_VALUES * VAL_W;
  localparam int IDX_W          = 5;
  localparam int CFG_IDX_W      = 2;
  localparam int NUM_W          = 52;
  localparam int ITER_W         = 6;

  // Quotient bits produced for each kind of division.
  localparam logic [ITER_W-1:0] ITER_RATIO  = 6'd16;
  localparam logic [ITER_W-1:0] ITER_THRUST = 6'd52;

  localparam logic [31:0] KILO_HALF  = 32'd32768000;
  localparam logic [31:0] FRAC_HALF  = 32'd32768;

  // floor(y / 125) equals (y * KILO_RECIP) >> KILO_SHIFT for every y below 2^31.
  localparam logic [31:0] KILO_RECIP = 32'd2199023256;
  localparam int          KILO_SHIFT = 38;

  localparam logic [2:0] K_MASS   = 3'd6;
  localparam logic [2:0] K_THRUST = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_HORIZON = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TMAX    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TMIN    = 2'd2;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [1:0] {
    STS_INTERP = 2'd0,
    STS_BEFORE = 2'd1,
    STS_AFTER  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SRD, S_SCMP, S_RDA, S_RDB, S_LDB, S_WRAT,
    S_MUL, S_PREP, S_START, S_WDIV, S_OUT
  } state_t;

  typedef struct packed {
    logic    tbl_wr;
    logic    tbl_clr;
    logic    q_ld;
    logic    tprev_ld;
    logic    ld_a;
    logic    ld_b;
    logic    ratio_start;
    logic    r_ld;
    logic    mul;
    logic    prep;
    logic    div_start;
    logic    held_wr;
    logic    held_div;
    logic    out_ld;
    status_t status;
    logic [2:0] k;
  } cmd_t;

  typedef struct packed {
    logic t_later;
    logic div_done;
    logic den_zero;
  } sts_t;

  // Applies a sign to a magnitude and clamps to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic neg, input logic [NUM_W-1:0] mag);
    logic [31:0] res;
    if (!neg) begin
      res = (mag > NUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : mag[31:0];
    end else begin
      res = (mag > NUM_W'(33'h0_8000_0000)) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/ttip_ram.sv =====
// Generic single-write, single-read memory with registered read data.
module ttip_ram #(
  parameter int W = 32,
  parameter int D = 32
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/ttip_div.sv =====
// Restoring divider producing one quotient bit per cycle.
module ttip_div
  import ttip_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [31:0]       rem_init,
  input  logic [NUM_W-1:0]  num,
  input  logic [31:0]       divisor,
  input  logic [ITER_W-1:0] iters,
  output logic              done,
  output logic [NUM_W-1:0]  quo
);

  logic [31:0]       rem_r;
  logic [NUM_W-1:0]  num_r;
  logic [NUM_W-1:0]  quo_r;
  logic [31:0]       div_r;
  logic [ITER_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [32:0] rem2;
  logic        ge;
  logic [31:0] rem_nxt;

  assign rem2    = {rem_r, num_r[NUM_W-1]};
  assign ge      = rem2 >= {1'b0, div_r};
  assign rem_nxt = ge ? 32'(rem2 - {1'b0, div_r}) : rem2[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= iters;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == ITER_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      num_r <= num;
      div_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== rtl/core/ttip_datapath.sv =====
// Datapath: waypoint memories, interpolation arithmetic, divider and result register.
module ttip_datapath
  import ttip_pkg::*;
#(
  parameter int NUM_POINTS = NUM_POINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cmd_t                          cmd,
  input  logic [$clog2(NUM_POINTS)-1:0] addr,
  output sts_t                          sts,
  input  logic [IDX_W-1:0]              in_entry_index,
  input  logic [31:0]                   in_sample_time,
  input  logic [ROW_W-1:0]              in_values,
  input  logic [31:0]                   horizon_offset,
  input  logic [31:0]                   thrust_max,
  input  logic [31:0]                   thrust_min,
  output logic [1:0]                    out_status,
  output logic [ROW_W-1:0]              out_data
);

  localparam int AW = $clog2(NUM_POINTS);

  logic          tm_we;
  logic [AW-1:0] waddr;
  logic [31:0]   tm_rdata;
  logic [ROW_W-1:0] row_rdata;

  logic [32:0] t_r;
  logic [31:0] tprev_r;
  logic [31:0] row_a_r [NUM_VALUES];
  logic [31:0] row_b_r [NUM_VALUES];
  logic [15:0] r_r;
  logic signed [49:0] e_r;
  logic signed [NUM_W-1:0] n_r;
  logic        neg_r;
  logic [31:0] held_r [NUM_VALUES];
  logic [1:0]  out_status_r;
  logic [ROW_W-1:0] out_data_r;

  assign tm_we = cmd.tbl_wr | cmd.tbl_clr;
  assign waddr = cmd.tbl_clr ? addr : AW'(in_entry_index);

  ttip_ram #(.W(32), .D(NUM_POINTS)) u_times (
    .clk(clk), .we(tm_we), .waddr(waddr),
    .wdata(cmd.tbl_clr ? 32'd0 : in_sample_time),
    .raddr(addr), .rdata(tm_rdata)
  );

  ttip_ram #(.W(ROW_W), .D(NUM_POINTS)) u_values (
    .clk(clk), .we(tm_we), .waddr(waddr),
    .wdata(cmd.tbl_clr ? {ROW_W{1'b0}} : in_values),
    .raddr(addr), .rdata(row_rdata)
  );

  // Interpolation of one value: e = a * 2^16 + r * (b - a).
  logic signed [31:0] a_s, b_s;
  logic signed [32:0] diff;
  logic signed [49:0] prod;
  logic signed [49:0] e_nxt;

  assign a_s   = $signed(row_a_r[cmd.k]);
  assign b_s   = $signed(row_b_r[cmd.k]);
  assign diff  = {b_s[31], b_s} - {a_s[31], a_s};
  assign prod  = $signed({1'b0, r_r}) * diff;
  assign e_nxt = $signed({{2{a_s[31]}}, a_s, 16'd0}) + prod;

  // Thrust limits.
  logic signed [32:0] lim_sum, den;
  logic [31:0] den_abs;
  logic signed [NUM_W-1:0] n_nxt;

  assign lim_sum = {thrust_max[31], thrust_max} + {thrust_min[31], thrust_min};
  assign den     = {thrust_max[31], thrust_max} - {thrust_min[31], thrust_min};
  assign den_abs = den[32] ? 32'(-den) : den[31:0];
  assign n_nxt   = (cmd.k == K_THRUST)
                 ? ($signed({e_r[49], e_r, 1'b0}) - $signed({{3{lim_sum[32]}}, lim_sum, 16'd0}))
                 : $signed({{2{e_r[49]}}, e_r});

  // Sign and rounded magnitude of the value to divide.
  logic             neg;
  logic [NUM_W-1:0] mag, m_kilo, m_mass, m_thr;
  logic [NUM_W-1:0] div_num;
  logic [31:0]      div_rem, div_dsr;
  logic [ITER_W-1:0] div_iters;
  logic             div_done;
  logic [NUM_W-1:0] quo;

  assign mag    = n_r[NUM_W-1] ? NUM_W'(-n_r) : NUM_W'(n_r);
  assign neg    = n_r[NUM_W-1] ^ ((cmd.k == K_THRUST) & den[32]);
  assign m_kilo = mag + NUM_W'(KILO_HALF);
  assign m_mass = NUM_W'((mag + NUM_W'(FRAC_HALF)) >> 16);
  assign m_thr  = mag + NUM_W'(den_abs >> 1);

  always_comb begin
    if (cmd.ratio_start) begin
      div_rem   = 32'(t_r - {1'b0, tprev_r});
      div_num   = '0;
      div_dsr   = tm_rdata - tprev_r;
      div_iters = ITER_RATIO;
    end else begin
      div_rem   = '0;
      div_num   = m_thr;
      div_dsr   = den_abs;
      div_iters = ITER_THRUST;
    end
  end

  ttip_div u_div (
    .clk(clk), .rst_n(rst_n),
    .start(cmd.ratio_start | (cmd.div_start & (cmd.k == K_THRUST))),
    .rem_init(div_rem), .num(div_num), .divisor(div_dsr), .iters(div_iters),
    .done(div_done), .quo(quo)
  );

  // Position and speed: the rounded magnitude over 2^19 is divided by 125 through a
  // reciprocal multiply, with the operand registered in kilo_y_r and the product in kilo_q_r.
  logic [30:0] kilo_y_r;
  logic [24:0] kilo_q_r;
  logic        kilo_go_r, kilo_done_r, kilo_sel_r;
  logic [62:0] kilo_prod;

  assign kilo_prod = 63'(kilo_y_r) * 63'(KILO_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kilo_go_r   <= 1'b0;
      kilo_done_r <= 1'b0;
      kilo_sel_r  <= 1'b0;
    end else begin
      kilo_go_r   <= cmd.div_start & (cmd.k != K_THRUST);
      kilo_done_r <= kilo_go_r;
      if (cmd.ratio_start) kilo_sel_r <= 1'b0;
      else if (cmd.div_start) kilo_sel_r <= (cmd.k != K_THRUST);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) kilo_y_r <= m_kilo[49:19];
    if (kilo_go_r) kilo_q_r <= kilo_prod[62:KILO_SHIFT];
  end

  logic [31:0] held_val;
  always_comb begin
    if (cmd.held_div) begin
      held_val = (cmd.k == K_THRUST) ? sat32(neg_r, quo) : sat32(neg_r, NUM_W'(kilo_q_r));
    end else if (cmd.k == K_MASS) begin
      held_val = sat32(neg, m_mass);
    end else begin
      held_val = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_ld) begin
      t_r <= {1'b0, in_sample_time} + {1'b0, horizon_offset};
    end
    if (cmd.tprev_ld) begin
      tprev_r <= tm_rdata;
    end
    for (int i = 0; i < NUM_VALUES; i++) begin
      if (cmd.ld_a) row_a_r[i] <= row_rdata[i*VAL_W +: VAL_W];
      if (cmd.ld_b) row_b_r[i] <= row_rdata[i*VAL_W +: VAL_W];
    end
    if (cmd.r_ld) begin
      r_r <= quo[15:0];
    end
    if (cmd.mul) begin
      e_r <= e_nxt;
    end
    if (cmd.prep) begin
      n_r <= n_nxt;
    end
    if (cmd.div_start) begin
      neg_r <= neg;
    end
    if (cmd.out_ld) begin
      out_status_r <= cmd.status;
      for (int i = 0; i < NUM_VALUES; i++) begin
        out_data_r[i*VAL_W +: VAL_W] <= held_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_VALUES; i++) begin
        held_r[i] <= '0;
      end
    end else if (cmd.held_wr) begin
      held_r[cmd.k] <= held_val;
    end
  end

  assign sts.t_later  = {1'b0, tm_rdata} > t_r;
  assign sts.div_done = kilo_sel_r ? kilo_done_r : div_done;
  assign sts.den_zero = (den == 33'sd0);

  assign out_status = out_status_r;
  assign out_data   = out_data_r;

endmodule

// ===== rtl/core/ttip_ctrl.sv =====
// Controller: clearing pass, table scan and sequencing of the interpolation steps.
module ttip_ctrl
  import ttip_pkg::*;
#(
  parameter int NUM_POINTS = NUM_POINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_req_type,
  input  logic [IDX_W-1:0]              in_entry_index,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  input  sts_t                          sts,
  output cmd_t                          cmd,
  output logic [$clog2(NUM_POINTS)-1:0] addr
);

  localparam int AW = $clog2(NUM_POINTS);
  localparam logic [AW-1:0] LAST = AW'(NUM_POINTS - 1);

  state_t        state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [2:0]    k_r, k_nxt;
  status_t       status_r, status_nxt;
  logic          out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      k_r         <= '0;
      status_r    <= STS_INTERP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    k_nxt      = k_r;
    status_nxt = status_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    in_ready   = 1'b0;
    addr       = cnt_r;
    cmd        = '0;
    cmd.k      = k_r;
    cmd.status = status_r;

    unique case (state_r)
      S_CLEAR: begin
        cmd.tbl_clr = 1'b1;
        if (cnt_r == LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_req_type == REQ_QUERY) begin
            cmd.q_ld  = 1'b1;
            cnt_nxt   = '0;
            state_nxt = S_SRD;
          end else if (32'(in_entry_index) < NUM_POINTS) begin
            cmd.tbl_wr = 1'b1;
          end
        end
      end
      S_SRD: begin
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        if (sts.t_later) begin
          if (cnt_r == '0) begin
            status_nxt = STS_BEFORE;
            state_nxt  = S_OUT;
          end else begin
            cmd.ratio_start = 1'b1;
            state_nxt       = S_RDA;
          end
        end else begin
          cmd.tprev_ld = 1'b1;
          if (cnt_r == LAST) begin
            status_nxt = STS_AFTER;
            state_nxt  = S_OUT;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_SRD;
          end
        end
      end
      S_RDA: begin
        addr      = cnt_r - 1'b1;
        state_nxt = S_RDB;
      end
      S_RDB: begin
        cmd.ld_a  = 1'b1;
        state_nxt = S_LDB;
      end
      S_LDB: begin
        cmd.ld_b  = 1'b1;
        state_nxt = S_WRAT;
      end
      S_WRAT: begin
        if (sts.div_done) begin
          cmd.r_ld   = 1'b1;
          k_nxt      = '0;
          status_nxt = STS_INTERP;
          state_nxt  = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_START;
      end
      S_START: begin
        // Mass needs only a shift; equal thrust limits give zero.
        if (k_r == K_MASS || (k_r == K_THRUST && sts.den_zero)) begin
          cmd.held_wr = 1'b1;
          if (k_r == K_THRUST) begin
            state_nxt = S_OUT;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_MUL;
          end
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_WDIV;
        end
      end
      S_WDIV: begin
        if (sts.div_done) begin
          cmd.held_wr  = 1'b1;
          cmd.held_div = 1'b1;
          if (k_r == K_THRUST) begin
            state_nxt = S_OUT;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_MUL;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/trajectory_table_interpolator.sv =====
// A waypoint write is taken straight from the idle state. A query scans the time table
// entry by entry, then reads the two bracketing rows and runs the ratio division, takes
// each position/speed value through the reciprocal divide, mass through a shift, and the
// thrust through the bit-serial thrust division; the next request can be taken at the
// earliest in the cycle in which out_tvalid rises; a finished result waits in its register.
// After reset the table is cleared entry by entry while in_tready stays low.
module trajectory_table_interpolator
  import ttip_pkg::*;
#(
  parameter int NUM_POINTS = NUM_POINTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // entry_index, sample_time, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
  // fuel_mass, thrust_value; three zero pad bits on top
  input  logic [295:0]         in_tdata,
  // req_type
  input  logic                 in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // ref_pos_x, ref_pos_y, ref_pos_z, ref_vel_x, ref_vel_y, ref_vel_z,
  // ref_mass, ref_thrust_norm
  output logic [255:0]         out_tdata,
  // status
  output logic [1:0]           out_tuser,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int AW = $clog2(NUM_POINTS);

  logic [31:0] horizon_r, tmax_r, tmin_r;
  cmd_t        cmd;
  sts_t        sts;
  logic [AW-1:0] addr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      horizon_r <= 32'd131072;
      tmax_r    <= '0;
      tmin_r    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_HORIZON: horizon_r <= cfg_data;
        CFG_TMAX:    tmax_r    <= cfg_data;
        CFG_TMIN:    tmin_r    <= cfg_data;
        default:     ;
      endcase
    end
  end

  ttip_ctrl #(.NUM_POINTS(NUM_POINTS)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_req_type(in_tuser),
    .in_entry_index(in_tdata[IDX_W-1:0]), .in_ready(in_tready),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .sts(sts), .cmd(cmd), .addr(addr)
  );

  ttip_datapath #(.NUM_POINTS(NUM_POINTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .addr(addr), .sts(sts),
    .in_entry_index(in_tdata[IDX_W-1:0]),
    .in_sample_time(in_tdata[IDX_W +: 32]),
    .in_values(in_tdata[IDX_W + 32 +: ROW_W]),
    .horizon_offset(horizon_r), .thrust_max(tmax_r), .thrust_min(tmin_r),
    .out_status(out_tuser), .out_data(out_tdata)
  );

endmodule

// ===== tb/trajectory_table_interpolator_tb.sv =====
// Self-checking testbench for the trajectory table interpolator: waypoint loads and queries.
module trajectory_table_interpolator_tb;
  import ttip_pkg::*;

  localparam int          NPTS       = 32;
  localparam int          DRAIN_WAIT = 2 * NPTS + 400;
  localparam int          CYCLE_CAP  = 3000000;
  localparam int          ITEM_GOAL  = 850;
  localparam logic [1:0]  CFG_NONE   = 2'd3;

  typedef struct packed {
    logic [1:0]   status;
    logic [255:0] refs;
  } reference_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [295:0]         in_tdata = '0;
  logic                 in_tuser = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [255:0]         out_tdata;
  logic [1:0]           out_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  trajectory_table_interpolator dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block's state.
  logic [31:0]  horizon_q;
  logic [31:0]  tmax_q;
  logic [31:0]  tmin_q;
  logic [31:0]  wp_time [NPTS];
  logic [255:0] wp_vals [NPTS];
  logic [255:0] held_q;
  reference_t   pending_refs[$];

  int errors = 0;
  int items_sent = 0;
  int queries_sent = 0;
  int results_seen = 0;
  int status_count [3] = '{0, 0, 0};
  int burst_left = 0;
  longint cycles = 0;

  function automatic longint sx32(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Rounds to nearest with ties away from zero.
  function automatic longint div_nearest(longint n, longint d);
    logic   neg;
    longint un, ud, q;
    neg = (n < 0) != (d < 0);
    un  = (n < 0) ? -n : n;
    ud  = (d < 0) ? -d : d;
    q   = (un + ud / 2) / ud;
    return neg ? -q : q;
  endfunction

  function automatic void model_request(logic req, logic [4:0] idx, logic [31:0] st,
                                        logic [255:0] vals);
    longint     t, t0, dt, r, a, b, den;
    longint     e [8];
    int         i;
    reference_t exp_ref;
    if (req == REQ_WRITE) begin
      wp_time[idx] = st;
      wp_vals[idx] = vals;
      return;
    end
    t = longint'(st) + longint'(horizon_q);
    i = 0;
    while (i < NPTS && longint'(wp_time[i]) <= t) i++;
    if (i == 0) begin
      exp_ref.status = STS_BEFORE;
    end else if (i >= NPTS) begin
      exp_ref.status = STS_AFTER;
    end else begin
      t0 = longint'(wp_time[i-1]);
      dt = longint'(wp_time[i]) - t0;
      r  = ((t - t0) << 16) / dt;
      for (int k = 0; k < 8; k++) begin
        a    = sx32(wp_vals[i-1][32*k +: 32]);
        b    = sx32(wp_vals[i][32*k +: 32]);
        e[k] = a * 65536 + r * (b - a);
      end
      for (int k = 0; k < 6; k++)
        held_q[32*k +: 32] = clamp32(div_nearest(e[k], 64'sd65536000));
      held_q[32*K_MASS +: 32] = clamp32(div_nearest(e[K_MASS], 64'sd65536));
      den = sx32(tmax_q) - sx32(tmin_q);
      if (den == 0)
        held_q[32*K_THRUST +: 32] = '0;
      else
        held_q[32*K_THRUST +: 32] = clamp32(div_nearest(
            2 * e[K_THRUST] - (sx32(tmax_q) + sx32(tmin_q)) * 65536, den));
      exp_ref.status = STS_INTERP;
    end
    exp_ref.refs = held_q;
    pending_refs = {pending_refs, exp_ref};
    status_count[exp_ref.status]++;
  endfunction

  // Sends one request in bursts separated by random gaps.
  task automatic send_request(logic req, logic [4:0] idx, logic [31:0] st, logic [255:0] vals);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
    end
    burst_left--;
    in_tuser  <= req;
    in_tdata  <= {3'b000, vals, st, idx};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    model_request(req, idx, st, vals);
    items_sent++;
    if (req == REQ_QUERY) queries_sent++;
  endtask

  task automatic write_point(logic [4:0] idx, logic [31:0] st, logic [255:0] vals);
    send_request(REQ_WRITE, idx, st, vals);
  endtask

  task automatic query_at(logic [31:0] st);
    send_request(REQ_QUERY, 5'($urandom), st, {8{$urandom}});
  endtask

  // Waits until every expected reference has come and the block has gone quiet.
  task automatic drain;
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_refs.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_HORIZON: horizon_q = val;
      CFG_TMAX:    tmax_q = val;
      CFG_TMIN:    tmin_q = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_limits(logic [31:0] hz, logic [31:0] tmax, logic [31:0] tmin);
    drain();
    write_reg(CFG_HORIZON, hz);
    write_reg(CFG_TMAX, tmax);
    write_reg(CFG_TMIN, tmin);
  endtask

  function automatic logic [255:0] rand_vals();
    logic [255:0] v;
    for (int k = 0; k < 8; k++) v[32*k +: 32] = $urandom;
    return v;
  endfunction

  // After reset every time is zero, so any query lands past the last point.
  task automatic test_empty_table;
    query_at(32'h0000_0000);
    query_at(32'hFFFF_FFFF);
  endtask

  task automatic test_directed_table;
    set_limits(32'h0002_0000, 32'h000A_0000, 32'hFFF6_0000);
    write_reg(CFG_NONE, $urandom);
    write_point(5'd0, 32'd10 << 16, {8{32'h7FFF_FFFF}});
    write_point(5'd1, 32'd12 << 16, {8{32'h8000_0000}});
    for (int k = 2; k < NPTS; k++)
      write_point(k[4:0], (32'd10 + 2 * k) << 16, rand_vals());
    query_at(32'd7 << 16);                    // before the first point
    query_at(32'd8 << 16);                    // exactly on the first point
    query_at(32'd9 << 16);                    // halfway between the two extremes
    query_at(32'd9 << 16 | 32'hFFFF);
    query_at((32'd8 + 2 * (NPTS - 1)) << 16); // exactly on the last point
    query_at(((32'd8 + 2 * (NPTS - 1)) << 16) - 1);
    query_at(32'hFFFF_FFFF);                  // query time carries past 32 bits
    // Equal limits, then reversed limits, then limits so narrow that the thrust saturates.
    set_limits(32'h0000_0000, 32'h0001_0000, 32'h0001_0000);
    query_at(32'd11 << 16);
    set_limits(32'hFFFF_FFFF, 32'hFFCE_0000, 32'h0032_0000);
    query_at(32'd0);
    set_limits(32'h0, 32'h0000_0001, 32'h0000_0000);
    query_at(32'd11 << 16);
    query_at(32'd20 << 16);
  endtask

  task automatic test_random_tables;
    int          round_no;
    logic [31:0] t_acc;
    longint      target, span;
    logic [31:0] hz, tmax, tmin;
    round_no = 0;
    while (items_sent < ITEM_GOAL) begin
      case (round_no % 6)
        0: begin tmax = 32'h0064_0000; tmin = 32'hFF9C_0000; end
        1: begin tmax = 32'h7FFF_FFFF; tmin = 32'h8000_0000; end
        2: begin tmax = 32'h0; tmin = 32'h0; end
        3: begin tmax = $urandom; tmin = $urandom; end
        4: begin tmax = 32'h8000_0000; tmin = 32'h7FFF_FFFF; end
        default: begin tmax = $urandom_range(1, 1000); tmin = 32'h0; end
      endcase
      case (round_no % 4)
        0: hz = 32'h0;
        1: hz = 32'h0002_0000;
        2: hz = 32'hFFFF_FFFF;
        default: hz = $urandom;
      endcase
      set_limits(hz, tmax, tmin);
      t_acc = $urandom_range(0, 1 << 24);
      for (int k = 0; k < NPTS; k++) begin
        write_point(k[4:0], t_acc, rand_vals());
        case ($urandom_range(0, 5))
          0: t_acc += 1;
          1: t_acc += $urandom_range(1 << 24, 1 << 26);
          default: t_acc += $urandom_range(1, 1 << 18);
        endcase
      end
      span = longint'(wp_time[NPTS-1]) - longint'(wp_time[0]);
      for (int n = 0; n < 60; n++) begin
        case ($urandom_range(0, 19))
          0, 1, 2: write_point(5'($urandom), $urandom, rand_vals());  // unsorted noise
          3: query_at($urandom);
          default: begin
            target = longint'(wp_time[0]) - 64 + longint'($urandom) % (span + 128);
            query_at(32'(target - longint'(horizon_q)));
          end
        endcase
      end
      round_no++;
    end
  endtask

  // Receiver stalls in phases: always ready, half ready, mostly stalled.
  int rx_mode = 0;
  int rx_left = 0;
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(20, 300);
    end
    rx_left--;
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(0, 1);
      default: out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    reference_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_refs.size() == 0) begin
        $display("%0t: unexpected reference status=%0d data=%h", $time, out_tuser, out_tdata);
        errors++;
      end else begin
        want = pending_refs.pop_front();
        if (out_tuser !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_tuser);
          errors++;
        end
        for (int k = 0; k < 8; k++)
          if (out_tdata[32*k +: 32] !== want.refs[32*k +: 32]) begin
            $display("%0t: reference field %0d expected %h actual %h", $time, k,
                     want.refs[32*k +: 32], out_tdata[32*k +: 32]);
            errors++;
          end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("trajectory_table_interpolator test failed");
      $finish;
    end
  end

  initial begin
    horizon_q = 32'h0002_0000;
    tmax_q    = '0;
    tmin_q    = '0;
    held_q    = '0;
    for (int k = 0; k < NPTS; k++) begin
      wp_time[k] = '0;
      wp_vals[k] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_directed_table();
    test_random_tables();
    drain();
    $display("Sent %0d requests, %0d of them queries; checked %0d references.",
             items_sent, queries_sent, results_seen);
    $display("Statuses seen: %0d interpolated, %0d before first, %0d after last.",
             status_count[0], status_count[1], status_count[2]);
    if (errors == 0 && pending_refs.size() == 0) begin
      $display("trajectory_table_interpolator test passed");
    end else begin
      $display("trajectory_table_interpolator test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ttip_pkg.sv
rtl/core/ttip_ram.sv
rtl/core/ttip_div.sv
rtl/core/ttip_datapath.sv
rtl/core/ttip_ctrl.sv
rtl/core/trajectory_table_interpolator.sv
tb/trajectory_table_interpolator_tb.sv
